/* design/tfc_pkg.sv */
// ---------------------------------------------------------------------------
// tfc_pkg
// Shared types and constants of the TCP flow cache with timeouts.
// ---------------------------------------------------------------------------
package tfc_pkg;

   localparam int unsigned DEF_FLOW_ENTRIES = 32;

   localparam logic [15:0] ETHERTYPE_IPV4    = 16'h0800;
   localparam logic [7:0]  PROTO_TCP         = 8'd6;
   localparam logic [15:0] ETH_HDR_OCTETS    = 16'd14;
   localparam logic [5:0]  MIN_IP_HDR_OCTETS = 6'd20;
   localparam logic [5:0]  OCTETS_PER_WORD   = 6'd4;

   localparam logic [31:0] ACTIVE_TIMEOUT_RST   = 32'd60000000;
   localparam logic [31:0] INACTIVE_TIMEOUT_RST = 32'd60000000;

   localparam logic CSR_ACTIVE_TIMEOUT   = 1'b0;
   localparam logic CSR_INACTIVE_TIMEOUT = 1'b1;

   localparam logic REQ_PACKET = 1'b0;
   localparam logic REQ_FLUSH  = 1'b1;

   typedef struct packed {
      logic load;
      logic scan_clr;
      logic scan_step;
      logic rd_scan;
      logic ring_rd;
      logic rd_ring;
      logic hit_upd;
      logic pop;
      logic alloc;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic req_flush;
      logic req_drop;
      logic match;
      logic scan_last;
      logic ring_empty;
      logic ring_full;
      logic head_due;
   } sts_type;

endpackage

/* design/tfc_ctrl.sv */
// ---------------------------------------------------------------------------
// tfc_ctrl
// Sequencer of the flow cache: lookup scan, update, allocation, expiry and flush.
// ---------------------------------------------------------------------------
module tfc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tfc_pkg::sts_type sts,
   output tfc_pkg::cmd_type cmd
);

   typedef enum logic [9:0] {
      S_IDLE     = 10'b0000000001,
      S_SCAN_RD  = 10'b0000000010,
      S_SCAN_CMP = 10'b0000000100,
      S_HIT_RD   = 10'b0000001000,
      S_HIT_UPD  = 10'b0000010000,
      S_HEAD_RD  = 10'b0000100000,
      S_HEAD_ENT = 10'b0001000000,
      S_HEAD_CHK = 10'b0010000000,
      S_ALLOC    = 10'b0100000000,
      S_FINISH   = 10'b1000000000
   } state_type;

   typedef enum logic [2:0] {
      M_EXPIRE = 3'b001,
      M_FULL   = 3'b010,
      M_FLUSH  = 3'b100
   } mode_type;

   state_type state_ff, state_in;
   mode_type  mode_ff, mode_in;

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (sts.req_flush) begin
                  mode_in  = M_FLUSH;
                  state_in = S_HEAD_RD;
               end else if (!sts.req_drop) begin
                  cmd.scan_clr = 1'b1;
                  state_in     = S_SCAN_RD;
               end
            end
         end
         S_SCAN_RD: begin
            cmd.rd_scan = 1'b1;
            state_in    = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            cmd.scan_step = 1'b1;
            if (sts.match) begin
               state_in = S_HIT_RD;
            end else if (sts.scan_last) begin
               if (sts.ring_full) begin
                  mode_in  = M_FULL;
                  state_in = S_HEAD_RD;
               end else begin
                  state_in = S_ALLOC;
               end
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_HIT_RD: begin
            cmd.rd_scan = 1'b1;
            state_in    = S_HIT_UPD;
         end
         S_HIT_UPD: begin
            cmd.hit_upd = 1'b1;
            mode_in     = M_EXPIRE;
            state_in    = S_HEAD_RD;
         end
         S_HEAD_RD: begin
            if (sts.ring_empty) begin
               state_in = S_FINISH;
            end else begin
               cmd.ring_rd = 1'b1;
               state_in    = S_HEAD_ENT;
            end
         end
         S_HEAD_ENT: begin
            cmd.rd_ring = 1'b1;
            state_in    = S_HEAD_CHK;
         end
         S_HEAD_CHK: begin
            if (mode_ff != M_EXPIRE || sts.head_due) begin
               cmd.pop  = 1'b1;
               state_in = (mode_ff == M_FULL) ? S_ALLOC : S_HEAD_RD;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_ALLOC: begin
            cmd.alloc = 1'b1;
            mode_in   = M_EXPIRE;
            state_in  = S_HEAD_RD;
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff  <= M_EXPIRE;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   a_onehot_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.hit_upd, cmd.pop, cmd.alloc, cmd.finish}))
      else $error("tfc_ctrl: conflicting table commands");
   a_alloc_after_pop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ALLOC && mode_ff == M_FULL) |-> $past(cmd.pop))
      else $error("tfc_ctrl: full-table allocation without eviction");
   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> !busy)
      else $error("tfc_ctrl: finish did not return to idle");

endmodule

/* design/tfc_dpath.sv */
// ---------------------------------------------------------------------------
// tfc_dpath
// Flow table storage, age ring, timeout checks and record output register.
// ---------------------------------------------------------------------------
module tfc_dpath #(
   parameter int unsigned FLOW_ENTRIES = tfc_pkg::DEF_FLOW_ENTRIES
) (
   input  logic             clock,
   input  logic             reset,
   input  tfc_pkg::cmd_type cmd,
   output tfc_pkg::sts_type sts,
   input  logic             csr_write_enable,
   input  logic             csr_index,
   input  logic [31:0]      csr_write_data,
   input  logic             req_type,
   input  logic [15:0]      req_ether_type,
   input  logic [3:0]       req_ip_hdr_words,
   input  logic [7:0]       req_ip_protocol,
   input  logic [31:0]      req_src_address,
   input  logic [31:0]      req_dst_address,
   input  logic [7:0]       req_type_of_service,
   input  logic [15:0]      req_src_port_in,
   input  logic [15:0]      req_dst_port_in,
   input  logic [7:0]       req_tcp_flag_bits,
   input  logic [15:0]      req_frame_length,
   input  logic [47:0]      req_arrival_time,
   output logic             rsp_strobe,
   output logic [31:0]      rsp_rec_src_address,
   output logic [31:0]      rsp_rec_dst_address,
   output logic [15:0]      rsp_rec_src_port,
   output logic [15:0]      rsp_rec_dst_port,
   output logic [7:0]       rsp_rec_tos,
   output logic [31:0]      rsp_rec_packets,
   output logic [31:0]      rsp_rec_octets,
   output logic [47:0]      rsp_rec_first_time,
   output logic [47:0]      rsp_rec_last_time,
   output logic [7:0]       rsp_rec_tcp_flags,
   output logic             rsp_last_record
);

   localparam int unsigned IW = $clog2(FLOW_ENTRIES);
   localparam int unsigned CW = $clog2(FLOW_ENTRIES + 1);
   localparam int unsigned RW = 32 + 32 + 16 + 16 + 8 + 32 + 32 + 48 + 48 + 8;

   function automatic logic reached(input logic [47:0] now, input logic [47:0] since,
                                    input logic [31:0] limit);
      logic [48:0] diff;
      diff = {1'b0, now} - {1'b0, since};
      return !diff[48] && (diff[47:0] >= {16'd0, limit});
   endfunction

   logic [31:0] active_ff, inactive_ff;

   logic [95:0] key_ff;
   logic [7:0]  tos_ff, flags_ff;
   logic [31:0] size_ff;
   logic [47:0] time_ff;
   logic [31:0] size_in;

   logic [95:0] key_mem   [FLOW_ENTRIES];
   logic [63:0] count_mem [FLOW_ENTRIES];
   logic [47:0] first_mem [FLOW_ENTRIES];
   logic [47:0] last_mem  [FLOW_ENTRIES];
   logic [15:0] tf_mem    [FLOW_ENTRIES];
   logic [IW-1:0] ring_mem [FLOW_ENTRIES];

   logic [95:0] key_q;
   logic [63:0] count_q;
   logic [47:0] first_q, last_q;
   logic [15:0] tf_q;
   logic [IW-1:0] ring_q;
   logic [IW-1:0] ent_idx_ff;

   logic [FLOW_ENTRIES-1:0] valid_ff;
   logic [IW-1:0] scan_idx_ff, free_ff, head_ff;
   logic          free_found_ff;
   logic [CW-1:0] count_ff;

   logic          rd_en;
   logic [IW-1:0] rd_addr;
   logic          wr_en, restart;
   logic [IW-1:0] wr_addr;
   logic [63:0]   count_wr;
   logic [47:0]   first_wr;
   logic [15:0]   tf_wr;
   logic [CW:0]   tail_sum;
   logic [IW-1:0] tail;
   logic          timed_out, emit;
   logic [RW-1:0] rec_new, pend_ff, out_ff;
   logic          pend_v_ff, strobe_ff, last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= tfc_pkg::ACTIVE_TIMEOUT_RST;
         inactive_ff <= tfc_pkg::INACTIVE_TIMEOUT_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            tfc_pkg::CSR_ACTIVE_TIMEOUT:   active_ff   <= csr_write_data;
            tfc_pkg::CSR_INACTIVE_TIMEOUT: inactive_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign size_in = (req_frame_length >= tfc_pkg::ETH_HDR_OCTETS) ?
                    {16'd0, req_frame_length - tfc_pkg::ETH_HDR_OCTETS} : 32'd0;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff   <= {req_src_address, req_dst_address, req_src_port_in, req_dst_port_in};
         tos_ff   <= req_type_of_service;
         flags_ff <= req_tcp_flag_bits;
         size_ff  <= size_in;
         time_ff  <= req_arrival_time;
      end
   end

   assign sts.req_flush = (req_type == tfc_pkg::REQ_FLUSH);
   assign sts.req_drop  = (req_ether_type != tfc_pkg::ETHERTYPE_IPV4) ||
                          ({2'b00, req_ip_hdr_words} * tfc_pkg::OCTETS_PER_WORD
                           < tfc_pkg::MIN_IP_HDR_OCTETS) ||
                          (req_ip_protocol != tfc_pkg::PROTO_TCP);
   assign sts.match      = valid_ff[scan_idx_ff] && (key_q == key_ff);
   assign sts.scan_last  = (scan_idx_ff == IW'(FLOW_ENTRIES - 1));
   assign sts.ring_empty = (count_ff == '0);
   assign sts.ring_full  = (count_ff == CW'(FLOW_ENTRIES));
   assign sts.head_due   = reached(time_ff, first_q, active_ff);

   assign timed_out = reached(time_ff, last_q, inactive_ff) ||
                      reached(time_ff, first_q, active_ff);

   assign rd_en   = cmd.rd_scan || cmd.rd_ring;
   assign rd_addr = cmd.rd_ring ? ring_q : scan_idx_ff;

   assign restart = cmd.alloc || timed_out;
   assign wr_en   = cmd.hit_upd || cmd.alloc;
   assign wr_addr = cmd.alloc ? free_ff : scan_idx_ff;

   always_comb begin
      if (restart) begin
         count_wr = {32'd1, size_ff};
         first_wr = time_ff;
         tf_wr    = {tos_ff, flags_ff};
      end else begin
         count_wr = {count_q[63:32] + 32'd1, count_q[31:0] + size_ff};
         first_wr = first_q;
         tf_wr    = {tf_q[15:8], tf_q[7:0] | flags_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         count_mem[wr_addr] <= count_wr;
         first_mem[wr_addr] <= first_wr;
         last_mem[wr_addr]  <= time_ff;
         tf_mem[wr_addr]    <= tf_wr;
      end
      if (cmd.alloc) begin
         key_mem[free_ff] <= key_ff;
      end
      if (rd_en) begin
         key_q      <= key_mem[rd_addr];
         count_q    <= count_mem[rd_addr];
         first_q    <= first_mem[rd_addr];
         last_q     <= last_mem[rd_addr];
         tf_q       <= tf_mem[rd_addr];
         ent_idx_ff <= rd_addr;
      end
   end

   assign tail_sum = {1'b0, CW'(head_ff)} + {1'b0, count_ff};
   assign tail     = (tail_sum >= (CW + 1)'(FLOW_ENTRIES)) ?
                     IW'(tail_sum - (CW + 1)'(FLOW_ENTRIES)) : IW'(tail_sum);

   always_ff @(posedge clock) begin
      if (cmd.alloc) begin
         ring_mem[tail] <= free_ff;
      end
      if (cmd.ring_rd) begin
         ring_q <= ring_mem[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         head_ff       <= '0;
         count_ff      <= '0;
         scan_idx_ff   <= '0;
         free_found_ff <= 1'b0;
      end else begin
         if (cmd.scan_clr) begin
            scan_idx_ff   <= '0;
            free_found_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            if (!valid_ff[scan_idx_ff] && !free_found_ff) begin
               free_found_ff <= 1'b1;
            end
            if (!sts.match && !sts.scan_last) begin
               scan_idx_ff <= scan_idx_ff + IW'(1);
            end
         end
         if (cmd.alloc) begin
            valid_ff[free_ff] <= 1'b1;
            count_ff          <= count_ff + CW'(1);
         end
         if (cmd.pop) begin
            valid_ff[ent_idx_ff] <= 1'b0;
            count_ff             <= count_ff - CW'(1);
            head_ff <= (head_ff == IW'(FLOW_ENTRIES - 1)) ? '0 : head_ff + IW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_step && !valid_ff[scan_idx_ff] && !free_found_ff) begin
         free_ff <= scan_idx_ff;
      end else if (cmd.pop) begin
         free_ff <= ent_idx_ff;
      end
   end

   // A record is held back in a pending register so that the final one can carry the last flag.
   assign emit    = cmd.pop || (cmd.hit_upd && timed_out);
   assign rec_new = {key_q, tf_q[15:8], count_q, first_q, last_q, tf_q[7:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         if (emit) begin
            pend_v_ff <= 1'b1;
            strobe_ff <= pend_v_ff;
         end else if (cmd.finish) begin
            pend_v_ff <= 1'b0;
            strobe_ff <= pend_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         pend_ff <= rec_new;
         out_ff  <= pend_ff;
         last_ff <= 1'b0;
      end else if (cmd.finish) begin
         out_ff  <= pend_ff;
         last_ff <= 1'b1;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign {rsp_rec_src_address, rsp_rec_dst_address, rsp_rec_src_port, rsp_rec_dst_port,
           rsp_rec_tos, rsp_rec_packets, rsp_rec_octets, rsp_rec_first_time,
           rsp_rec_last_time, rsp_rec_tcp_flags} = out_ff;
   assign rsp_last_record = last_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(FLOW_ENTRIES))
      else $error("tfc_dpath: ring count beyond table size");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> count_ff != '0)
      else $error("tfc_dpath: eviction from an empty ring");
   a_last_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last_record) |=> !rsp_strobe)
      else $error("tfc_dpath: beat after the last record");

endmodule

/* design/tcp_flow_cache_with_timeouts_top.sv */
// ---------------------------------------------------------------------------
// tcp_flow_cache_with_timeouts_top
// TCP flow cache with active and inactive timeouts, exporting flow records.
//
//   Channel  Handshake               Payload
//   req      start & !busy           req_type .. req_arrival_time
//   rsp      rsp_strobe (one cycle)  rsp_rec_* , rsp_last_record
//   csr      csr_write_enable        csr_index, csr_write_data
//
// Every request spends its accepting cycle in idle; a dropped packet ends there.
// A kept packet reads and compares one entry at a time, stopping at a hit or
// after the last entry. A hit then reads and updates the entry; a miss allocates
// one, preceded by the eviction of the oldest flow when the table is full. Each
// head of the age ring is then read and checked for expiry until one is not due
// or the ring is empty, and a finish step returns to idle.
// A flush evicts every flow in ring order and then finishes.
// Reset is synchronous and leaves the table empty; no clearing pass is run.
// Records leave one beat per cycle at most and cannot be held off.
// ---------------------------------------------------------------------------
module tcp_flow_cache_with_timeouts_top #(
   parameter int unsigned FLOW_ENTRIES = tfc_pkg::DEF_FLOW_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_type,
   input  logic [15:0] req_ether_type,
   input  logic [3:0]  req_ip_hdr_words,
   input  logic [7:0]  req_ip_protocol,
   input  logic [31:0] req_src_address,
   input  logic [31:0] req_dst_address,
   input  logic [7:0]  req_type_of_service,
   input  logic [15:0] req_src_port_in,
   input  logic [15:0] req_dst_port_in,
   input  logic [7:0]  req_tcp_flag_bits,
   input  logic [15:0] req_frame_length,
   input  logic [47:0] req_arrival_time,
   output logic        rsp_strobe,
   output logic [31:0] rsp_rec_src_address,
   output logic [31:0] rsp_rec_dst_address,
   output logic [15:0] rsp_rec_src_port,
   output logic [15:0] rsp_rec_dst_port,
   output logic [7:0]  rsp_rec_tos,
   output logic [31:0] rsp_rec_packets,
   output logic [31:0] rsp_rec_octets,
   output logic [47:0] rsp_rec_first_time,
   output logic [47:0] rsp_rec_last_time,
   output logic [7:0]  rsp_rec_tcp_flags,
   output logic        rsp_last_record,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [31:0] csr_write_data
);

   tfc_pkg::cmd_type cmd;
   tfc_pkg::sts_type sts;

   tfc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   tfc_dpath #(
      .FLOW_ENTRIES (FLOW_ENTRIES)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_type            (req_type),
      .req_ether_type      (req_ether_type),
      .req_ip_hdr_words    (req_ip_hdr_words),
      .req_ip_protocol     (req_ip_protocol),
      .req_src_address     (req_src_address),
      .req_dst_address     (req_dst_address),
      .req_type_of_service (req_type_of_service),
      .req_src_port_in     (req_src_port_in),
      .req_dst_port_in     (req_dst_port_in),
      .req_tcp_flag_bits   (req_tcp_flag_bits),
      .req_frame_length    (req_frame_length),
      .req_arrival_time    (req_arrival_time),
      .rsp_strobe          (rsp_strobe),
      .rsp_rec_src_address (rsp_rec_src_address),
      .rsp_rec_dst_address (rsp_rec_dst_address),
      .rsp_rec_src_port    (rsp_rec_src_port),
      .rsp_rec_dst_port    (rsp_rec_dst_port),
      .rsp_rec_tos         (rsp_rec_tos),
      .rsp_rec_packets     (rsp_rec_packets),
      .rsp_rec_octets      (rsp_rec_octets),
      .rsp_rec_first_time  (rsp_rec_first_time),
      .rsp_rec_last_time   (rsp_rec_last_time),
      .rsp_rec_tcp_flags   (rsp_rec_tcp_flags),
      .rsp_last_record     (rsp_last_record)
   );

endmodule
